FILE: hw/rtl/wesc_pkg.sv
// ----------------------------------------------------------------------------
// Wheel encoder sync controller package
// Word types, register indexes and move mode codes shared by the controller.
// ----------------------------------------------------------------------------
package wesc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_MOVE_MODE   = 3'd0;
    localparam logic [2:0] REG_BASE_SPEED  = 3'd1;
    localparam logic [2:0] REG_GAIN        = 3'd2;
    localparam logic [2:0] REG_TARGET      = 3'd3;
    localparam logic [2:0] REG_COLOR       = 3'd4;

    // Move mode codes. All other codes are idle.
    localparam logic [2:0] MODE_LEFT       = 3'd0;
    localparam logic [2:0] MODE_RIGHT      = 3'd1;
    localparam logic [2:0] MODE_SYNC_COLOR = 3'd2;
    localparam logic [2:0] MODE_SYNC       = 3'd4;
    localparam logic [2:0] MODE_SYNC_STOP  = 3'd6;
    localparam logic [2:0] MODE_IDLE       = 3'd7;

    // Reset values of the configuration registers.
    localparam logic signed [15:0] BASE_SPEED_RST = 16'sd0;
    localparam logic [17:0]        GAIN_RST       = 18'd5033;
    localparam logic [23:0]        TARGET_RST     = 24'd30750;
    localparam logic [2:0]         COLOR_RST      = 3'd0;

    // Input word command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Largest difference magnitude fed to the gain multiplier.
    localparam int             MAG_W       = 45;
    localparam logic [63:0]    DIFF_CLAMP  = (64'd1 << MAG_W) - 64'd1;

    typedef struct packed {
        logic              cmd;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [2:0]         color_seen;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               left_update;
        logic               right_update;
        logic               busy_res;
    } t_out_word;

endpackage

FILE: hw/rtl/wheel_encoder_sync_controller_core.sv
// ----------------------------------------------------------------------------
// Wheel encoder sync controller core
// Drives one wheel to a target or keeps two wheels level with a proportional
// correction on the lagging wheel; one result word for every input word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                     Word
//  input     in         i_in_valid / o_in_ready       t_in_word
//  output    out        o_out_valid / i_out_ready     t_out_word
//  config    in         i_cfg_we (no back-pressure)   i_cfg_idx, i_cfg_data
//
// A word accepted into the input register goes through the difference, gain
// multiply and saturating add into the result register once the result
// register is free or being emptied. A new word can be accepted every cycle
// while the compute stage moves or the input register is empty.
// Reset (synchronous, active low) clears the move state, start points, both
// valid flags and loads the register defaults. When the result register is
// full and not taken, the input register still accepts one more word.
//
module wheel_encoder_sync_controller_core #(
    parameter int COUNT_BITS   = 32,
    parameter int COLOR_WEIGHT = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wesc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wesc_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data
);
    import wesc_pkg::*;

    // Encoder counts are sign-extended from bit CNT_W-1 of the input fields.
    localparam int CNT_W = (COUNT_BITS < 32) ? COUNT_BITS : 32;
    // Width for the target compare: count, start and 24-bit target summed.
    localparam int SW    = ((CNT_W > 24) ? CNT_W : 24) + 2;
    // Width of the difference in pulses with 16 fractional bits plus color.
    localparam int DDW   = CNT_W + 18;
    localparam logic signed [17:0] CW_S = 18'(COLOR_WEIGHT);

    // Configuration registers.
    logic [2:0]         r_mode;
    logic signed [15:0] r_base;
    logic [17:0]        r_gain;
    logic [23:0]        r_target;
    logic [2:0]         r_color;

    // Move state.
    logic                    r_moving,      n_moving;
    logic signed [CNT_W-1:0] r_left_start,  n_left_start;
    logic signed [CNT_W-1:0] r_right_start, n_right_start;

    // Pipeline registers.
    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out, n_out;

    logic s2_fire;

    // The compute stage moves when the result register is free or being
    // emptied; the input register refills whenever it moves or is empty.
    assign s2_fire    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || s2_fire;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // Configuration writes must only be issued while the block is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_base   <= BASE_SPEED_RST;
            r_gain   <= GAIN_RST;
            r_target <= TARGET_RST;
            r_color  <= COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MOVE_MODE:  r_mode   <= i_cfg_data[2:0];
                REG_BASE_SPEED: r_base   <= i_cfg_data[15:0];
                REG_GAIN:       r_gain   <= i_cfg_data[17:0];
                REG_TARGET:     r_target <= i_cfg_data;
                REG_COLOR:      r_color  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    // Result register and move state; the state advances with the word that
    // produced it, so the next word in the input register sees it at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld     <= 1'b0;
            r_moving      <= 1'b0;
            r_left_start  <= '0;
            r_right_start <= '0;
        end else begin
            if (s2_fire) begin
                r_out_vld     <= 1'b1;
                r_moving      <= n_moving;
                r_left_start  <= n_left_start;
                r_right_start <= n_right_start;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Datapath from the input register to the result register.
    // ------------------------------------------------------------------
    logic signed [CNT_W-1:0] x_cnt, y_cnt;
    logic signed [SW-1:0]    x_ext, y_ext, tgt_ext;
    logic                    left_done, right_done;
    logic signed [CNT_W:0]   cnt_diff;
    logic signed [3:0]       color_diff;
    logic signed [21:0]      color_term;
    logic signed [DDW-1:0]   diff_q16;
    logic [DDW-1:0]          diff_mag;
    logic [MAG_W-1:0]        mag_clamped;
    logic [62:0]             product;
    logic [37:0]             corr;
    logic signed [39:0]      corr_sum;
    logic signed [15:0]      fast_speed;
    logic                    is_sync;

    always_comb begin
        x_cnt   = r_in.left_count[CNT_W-1:0];
        y_cnt   = r_in.right_count[CNT_W-1:0];
        x_ext   = SW'(x_cnt);
        y_ext   = SW'(y_cnt);
        tgt_ext = SW'($signed({1'b0, r_target}));

        left_done  = x_ext >= (SW'(r_left_start) + tgt_ext);
        right_done = y_ext >= (SW'(r_right_start) + tgt_ext);

        // Difference in pulses with 16 fractional bits, color term in mode 2.
        cnt_diff   = (CNT_W+1)'(y_cnt) - (CNT_W+1)'(x_cnt);
        color_diff = $signed({1'b0, r_color}) - $signed({1'b0, r_in.color_seen});
        color_term = 22'(color_diff) * 22'(CW_S);
        diff_q16   = DDW'($signed({cnt_diff, 16'b0}));
        if (r_mode == MODE_SYNC_COLOR) begin
            diff_q16 = diff_q16 + DDW'(color_term);
        end

        diff_mag    = diff_q16[DDW-1] ? unsigned'(-diff_q16) : unsigned'(diff_q16);
        mag_clamped = (64'(diff_mag) > DIFF_CLAMP) ? DIFF_CLAMP[MAG_W-1:0]
                                                   : MAG_W'(diff_mag);
        product     = 63'(mag_clamped) * 63'(r_gain);
        corr        = product[62:25];
        corr_sum    = 40'(r_base) + $signed({2'b00, corr});
        if (corr_sum > 40'sd32767) begin
            fast_speed = 16'sh7fff;
        end else if (corr_sum < -40'sd32768) begin
            fast_speed = 16'sh8000;
        end else begin
            fast_speed = corr_sum[15:0];
        end

        is_sync = (r_mode == MODE_SYNC_COLOR) || (r_mode == MODE_SYNC) ||
                  (r_mode == MODE_SYNC_STOP);
    end

    // Command decision for one word.
    always_comb begin
        n_moving      = r_moving;
        n_left_start  = r_left_start;
        n_right_start = r_right_start;
        n_out         = '0;

        if (r_in.cmd == CMD_START) begin
            // A start while a move is running is ignored.
            if (!r_moving) begin
                n_left_start  = '0;
                n_right_start = '0;
                if (r_mode == MODE_LEFT || is_sync) begin
                    n_left_start      = x_cnt;
                    n_out.left_speed  = r_base;
                    n_out.left_update = 1'b1;
                    n_moving          = 1'b1;
                end
                if (r_mode == MODE_RIGHT || is_sync) begin
                    n_right_start      = y_cnt;
                    n_out.right_speed  = r_base;
                    n_out.right_update = 1'b1;
                    n_moving           = 1'b1;
                end
            end
        end else if (r_moving) begin
            if (r_mode == MODE_LEFT) begin
                if (left_done) begin
                    n_out.left_update = 1'b1;
                    n_moving          = 1'b0;
                end
            end else if (r_mode == MODE_RIGHT) begin
                if (right_done) begin
                    n_out.right_update = 1'b1;
                    n_moving           = 1'b0;
                end
            end else if (is_sync) begin
                // The lagging wheel gets the correction; equal counts leave
                // both wheels alone.
                if (x_cnt != y_cnt) begin
                    n_out.left_speed   = r_base;
                    n_out.right_speed  = r_base;
                    if (!diff_q16[DDW-1] && diff_q16 != '0) begin
                        n_out.left_speed = fast_speed;
                    end else if (diff_q16[DDW-1]) begin
                        n_out.right_speed = fast_speed;
                    end
                    n_out.left_update  = 1'b1;
                    n_out.right_update = 1'b1;
                end
                if (r_mode == MODE_SYNC_STOP) begin
                    if (left_done) begin
                        n_out.left_speed  = '0;
                        n_out.left_update = 1'b1;
                    end
                    if (right_done) begin
                        n_out.right_speed  = '0;
                        n_out.right_update = 1'b1;
                    end
                    if (left_done && right_done) begin
                        n_moving = 1'b0;
                    end
                end
            end else begin
                // An idle mode during a move stops both wheels.
                n_out.left_update  = 1'b1;
                n_out.right_update = 1'b1;
                n_moving           = 1'b0;
            end
        end

        n_out.busy_res = n_moving;
    end

`ifndef SYNTHESIS
    // The busy flag of a result always matches the move state it left behind.
    a_busy_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire |=> (o_out_word.busy_res == r_moving))
        else $error("busy_res differs from move state");

    // A wheel that is not commanded reports a zero speed.
    a_left_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.left_update) |-> (o_out_word.left_speed == 16'sd0))
        else $error("left speed set without update");

    a_right_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.right_update) |-> (o_out_word.right_speed == 16'sd0))
        else $error("right speed set without update");

    // A tick never begins a move.
    a_tick_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && r_in.cmd == CMD_TICK && !r_moving) |=> !r_moving)
        else $error("move started by a tick");
`endif

endmodule
